// ===== hdl/ipv4_dotted_quad_line_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// IPv4 line parser assertion macros
// Shorthand for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef IPV4_DOTTED_QUAD_LINE_PARSER_UNIT_ASSERT_SVH
`define IPV4_DOTTED_QUAD_LINE_PARSER_UNIT_ASSERT_SVH

// Assertion on an explicit clock and active-low reset
`define IPV4Q_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset
`define IPV4Q_ASSERT(lbl, prop, msg) \
  `IPV4Q_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/ipv4q_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 line parser package
// Shared types and character constants.
// ----------------------------------------------------------------------------
package ipv4q_pkg;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] MAGIC_RESET = 8'd46;

  // one input character transfer
  typedef struct packed {
    logic [7:0] code;
    logic       present;
    logic       last;
  } item_t;

  // one line result, octets[0] is the first octet
  typedef struct packed {
    logic            ip_found;
    logic            has_magic;
    logic [3:0][7:0] octets;
  } result_t;

endpackage

// ===== hdl/ipv4q_in_stage.sv =====
// ----------------------------------------------------------------------------
// IPv4 line parser input register
// Captures one character transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module ipv4q_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ipv4q_pkg::item_t in_item_i,
  output logic            item_valid_o,
  output ipv4q_pkg::item_t item_o,
  input  logic            item_pop_i
);
  import ipv4q_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || item_pop_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (item_pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== hdl/ipv4q_parse_core.sv =====
// ----------------------------------------------------------------------------
// IPv4 line parser core
// Per-line parse state, one character per step, result on the line end.
// ----------------------------------------------------------------------------
module ipv4q_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [7:0]        cfg_wr_data_i,
  input  logic              step_i,
  input  ipv4q_pkg::item_t   item_i,
  output logic              res_valid_o,
  output ipv4q_pkg::result_t res_o
);
  import ipv4q_pkg::*;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_FAILED  = 2'd2;

  logic [7:0]      magic_q;
  logic [1:0]      status_q, status_d;
  logic [1:0]      pos_q, pos_d;
  logic [1:0]      dcnt_q, dcnt_d;
  logic [9:0]      acc_q, acc_d;
  logic [3:0]      lead_q, lead_d;
  logic [3:0]      dig2_q, dig2_d;
  logic [3:0][7:0] oct_q, oct_d;

  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] acc_x10;
  logic [7:0] dig2_x10;
  logic [7:0] last_three;
  logic       found;

  assign is_digit = (item_i.code >= CHAR_ZERO) && (item_i.code <= CHAR_NINE);
  assign digit    = 4'(item_i.code - CHAR_ZERO);
  assign acc_x10  = {acc_q[6:0], 3'b000} + {acc_q[8:0], 1'b0} + {6'd0, digit};
  assign dig2_x10 = {1'b0, dig2_q, 3'b000} + {3'b000, dig2_q, 1'b0};

  // third digit of the last octet: take the preferred alternative
  always_comb begin
    if (lead_q == 4'd2 && dig2_q == 4'd5 && digit <= 4'd5) begin
      last_three = 8'd250 + {4'd0, digit};
    end else if (lead_q == 4'd2 && dig2_q <= 4'd4) begin
      last_three = 8'd200 + dig2_x10 + {4'd0, digit};
    end else if (lead_q == 4'd1) begin
      last_three = 8'd100 + dig2_x10 + {4'd0, digit};
    end else begin
      last_three = acc_q[7:0];
    end
  end

  always_comb begin
    status_d = status_q;
    pos_d    = pos_q;
    dcnt_d   = dcnt_q;
    acc_d    = acc_q;
    lead_d   = lead_q;
    dig2_d   = dig2_q;
    oct_d    = oct_q;

    if (item_i.present && status_q == ST_PARSING) begin
      if (pos_q != 2'd3) begin
        if (is_digit) begin
          if (dcnt_q == 2'd3) begin
            status_d = ST_FAILED;
          end else begin
            acc_d  = acc_x10;
            dcnt_d = dcnt_q + 2'd1;
          end
        end else if (item_i.code == CHAR_DOT) begin
          if (dcnt_q == 2'd0 || acc_q > 10'd255) begin
            status_d = ST_FAILED;
          end else begin
            case (pos_q)
              2'd0:    oct_d[0] = acc_q[7:0];
              2'd1:    oct_d[1] = acc_q[7:0];
              default: oct_d[2] = acc_q[7:0];
            endcase
            pos_d  = pos_q + 2'd1;
            dcnt_d = 2'd0;
            acc_d  = 10'd0;
          end
        end else begin
          status_d = ST_FAILED;
        end
      end else if (!is_digit) begin
        if (dcnt_q == 2'd0) begin
          status_d = ST_FAILED;
        end else begin
          oct_d[3] = acc_q[7:0];
          status_d = ST_MATCHED;
        end
      end else if (dcnt_q == 2'd0) begin
        lead_d = digit;
        acc_d  = {6'd0, digit};
        dcnt_d = 2'd1;
      end else if (dcnt_q == 2'd1) begin
        acc_d  = acc_x10;
        dig2_d = digit;
        dcnt_d = 2'd2;
      end else begin
        oct_d[3] = last_three;
        status_d = ST_MATCHED;
      end
    end

    // close the line on its last transfer
    if (item_i.last && status_d == ST_PARSING) begin
      if (pos_d == 2'd3 && dcnt_d != 2'd0) begin
        oct_d[3] = acc_d[7:0];
        status_d = ST_MATCHED;
      end else begin
        status_d = ST_FAILED;
      end
    end
  end

  assign found = (status_d == ST_MATCHED);

  always_comb begin
    res_o.ip_found  = found;
    res_o.octets    = found ? oct_d : '0;
    res_o.has_magic = found && (oct_d[0] == magic_q || oct_d[1] == magic_q ||
                                oct_d[2] == magic_q || oct_d[3] == magic_q);
  end

  assign res_valid_o = step_i && item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MAGIC_RESET;
    end else if (cfg_wr_en_i) begin
      magic_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_PARSING;
      pos_q    <= 2'd0;
      dcnt_q   <= 2'd0;
      acc_q    <= 10'd0;
      lead_q   <= 4'd0;
    end else if (step_i) begin
      if (item_i.last) begin
        status_q <= ST_PARSING;
        pos_q    <= 2'd0;
        dcnt_q   <= 2'd0;
        acc_q    <= 10'd0;
        lead_q   <= 4'd0;
      end else begin
        status_q <= status_d;
        pos_q    <= pos_d;
        dcnt_q   <= dcnt_d;
        acc_q    <= acc_d;
        lead_q   <= lead_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dig2_q <= dig2_d;
      oct_q  <= oct_d;
    end
  end

endmodule

// ===== hdl/ipv4q_out_stage.sv =====
// ----------------------------------------------------------------------------
// IPv4 line parser result register
// Holds one line result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module ipv4q_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  ipv4q_pkg::result_t res_i,
  output logic              res_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipv4q_pkg::result_t out_o
);
  import ipv4q_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/ipv4_dotted_quad_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// IPv4 dotted-quad line parser
// Checks whether each text line starts with a dotted-quad address and
// reports the four octets and a match against a programmable octet value.
// ----------------------------------------------------------------------------
// Channel   Dir  Data            Side band
// s_axis    in   char_code       tuser: char_present, tlast: line end
// m_axis    out  octets a..d     tuser: ip_found, has_magic
// cfg       in   magic_value     write enable, no read-back
//
// One character per cycle, sustained while the input does not stall. A character
// is held in the input register; the parse state and result register update
// as it leaves it, so a line result passes the input register, then the result register.
// Reset clears the parse state and sets magic_value to 46. The input stalls
// only when a line end meets a full result register that is not being taken.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_line_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] char_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] a, [15:8] b, [23:16] c, [31:24] d
  output logic [1:0]  m_axis_tuser    // [0] ip_found, [1] has_magic
);
  import ipv4q_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_pop;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  assign in_item.code    = s_axis_tdata;
  assign in_item.present = s_axis_tuser[0];
  assign in_item.last    = s_axis_tlast;

  // advance unless a line end must wait for the result register
  assign item_pop = item_valid && (!item.last || res_ready);

  ipv4q_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  ipv4q_parse_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .step_i        (item_pop),
    .item_i        (item),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ipv4q_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = out_res.octets;
  assign m_axis_tuser = {out_res.has_magic, out_res.ip_found};

endmodule

// ===== hdl/ipv4q_checker.sv =====
// ----------------------------------------------------------------------------
// IPv4 line parser port checker
// Watches the top-level ports for result and stall consistency.
// ----------------------------------------------------------------------------
`include "ipv4_dotted_quad_line_parser_unit_assert.svh"

module ipv4q_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // hold a stalled result transfer
  `IPV4Q_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a line without an address reports zero octets and no magic hit
  `IPV4Q_ASSERT(a_not_found_clean, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0 && !m_axis_tuser[1], "not-found result carries data")

  // input backpressure only comes from a full, stalled result register
  `IPV4Q_ASSERT(a_stall_source, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule

bind ipv4_dotted_quad_line_parser_unit ipv4q_checker u_chk (.*);
